// ----- src/tsdg_pkg.sv -----
// shared types, constants and address map of the tile and sprite command generator
// no dependencies
package tsdg_pkg;

  // storage sizes
  localparam int unsigned MAP_TILES    = 2048;
  localparam int unsigned MAP_AW       = $clog2(MAP_TILES);
  localparam int unsigned SPR_WORDS    = 1024;
  localparam int unsigned SPR_AW       = $clog2(SPR_WORDS);
  localparam int unsigned SPR_IDX_W    = 10;

  // address map
  localparam logic [12:0] SPR_AREA     = 13'h02c0;   // 0x160000 >> 11
  localparam logic [11:0] FG_AREA      = 12'h320;    // 0x320000 >> 12
  localparam logic [11:0] BG_AREA      = 12'h322;    // 0x322000 >> 12
  localparam logic [23:0] SCRX0_ADDR   = 24'h300002;
  localparam logic [23:0] SCRX1_ADDR   = 24'h300006;
  localparam logic [23:0] SCRY0_ADDR   = 24'h300004;
  localparam logic [23:0] SCRY1_ADDR   = 24'h300008;
  localparam logic [23:0] BSEL_ADDR    = 24'h300000;
  localparam logic [23:0] GBANK_ADDR   = 24'h30000e;

  // screen arithmetic constants
  localparam logic [8:0]  SCRY_BIAS    = 9'd8;
  localparam logic [10:0] FG_SCRX_OFS  = 11'd1;
  localparam logic [10:0] BG_SCRX_OFS  = 11'd5;
  localparam logic [10:0] SPR_X_ORG    = 11'h13b;
  localparam logic [9:0]  SPR_Y_ORG    = 10'h101;
  localparam logic [8:0]  SPR_X_BIAS   = 9'h010;
  localparam logic [8:0]  SPR_Y_BIAS   = 9'd8;
  localparam logic [11:0] X_WRAP       = 12'h400;
  localparam logic [10:0] Y_WRAP       = 11'h200;
  localparam int          WRAP_LIMIT   = -15;

  typedef enum logic [1:0] {
    REQ_WORD   = 2'd0,
    REQ_BYTE   = 2'd1,
    REQ_TILE   = 2'd2,
    REQ_SPRITE = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    OP_FG_WR,
    OP_BG_WR,
    OP_SPR_WR,
    OP_SCRX_WR,
    OP_SCRY_WR,
    OP_BSEL_WR,
    OP_GBANK_WR,
    OP_TILE,
    OP_SPRITE
  } op_e;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_TILE,
    B_SPR0,
    B_SPR1,
    B_SPR2,
    B_EMIT
  } back_state_e;

  // decoded command from the front part
  typedef struct packed {
    op_e         op;
    logic [10:0] addr;     // map word, sprite word, map offset or register index
    logic [15:0] wdata;
    logic        lane_hi;
    logic        lane_lo;
    logic        layer;
    logic [10:0] idx;
  } cmd_t;

  // one draw command
  typedef struct packed {
    logic [14:0]        tile_code;
    logic signed [10:0] pos_x;
    logic signed [9:0]  pos_y;
    logic [6:0]         color;
    logic               flip_x;
    logic               flip_y;
    logic               sprite_graphics;
    logic               opaque;
    logic               last;
  } result_t;

endpackage

// ----- src/tsdg_ram.sv -----
// generic simple dual port ram with registered read
// no dependencies
module tsdg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/tsdg_front.sv -----
// front part: accepts requests, decodes bus addresses and classifies them
// depends on tsdg_pkg
module tsdg_front (
  input  logic          accept_i,
  input  logic [1:0]    req_type_i,
  input  logic [23:0]   bus_address_i,
  input  logic [15:0]   bus_data_i,
  input  logic          layer_select_i,
  input  logic [10:0]   item_index_i,
  output logic          cmd_push_o,
  output tsdg_pkg::cmd_t cmd_o
);

  logic        in_spr;
  logic        in_fg;
  logic        in_bg;
  logic        spr_ok;
  logic [23:0] word_addr;
  logic [7:0]  byte_data;
  logic        mapped;

  // address window decode
  assign in_spr    = bus_address_i[23:11] == tsdg_pkg::SPR_AREA;
  assign in_fg     = bus_address_i[23:12] == tsdg_pkg::FG_AREA;
  assign in_bg     = bus_address_i[23:12] == tsdg_pkg::BG_AREA;
  assign spr_ok    = {1'b0, bus_address_i[10:1]} < (tsdg_pkg::SPR_IDX_W + 1)'(tsdg_pkg::SPR_WORDS);
  assign word_addr = {bus_address_i[23:1], 1'b0};
  assign byte_data = bus_data_i[7:0];

  // classify the request into a command word
  always_comb begin
    cmd_o         = '0;
    cmd_o.op      = tsdg_pkg::OP_TILE;
    cmd_o.layer   = layer_select_i;
    cmd_o.idx     = item_index_i;
    mapped        = 1'b1;
    unique case (tsdg_pkg::req_e'(req_type_i))
      tsdg_pkg::REQ_WORD, tsdg_pkg::REQ_BYTE: begin
        if (req_type_i == tsdg_pkg::REQ_WORD) begin
          cmd_o.lane_hi = 1'b1;
          cmd_o.lane_lo = 1'b1;
          cmd_o.wdata   = bus_data_i;
        end else begin
          // even address is the high byte
          cmd_o.lane_hi = !bus_address_i[0];
          cmd_o.lane_lo = bus_address_i[0];
          cmd_o.wdata   = {byte_data, byte_data};
        end
        priority if (in_spr) begin
          cmd_o.op   = tsdg_pkg::OP_SPR_WR;
          cmd_o.addr = {1'b0, bus_address_i[10:1]};
          mapped     = spr_ok;
        end else if (in_fg) begin
          cmd_o.op   = tsdg_pkg::OP_FG_WR;
          cmd_o.addr = bus_address_i[11:1];
        end else if (in_bg) begin
          cmd_o.op   = tsdg_pkg::OP_BG_WR;
          cmd_o.addr = bus_address_i[11:1];
        end else if (req_type_i == tsdg_pkg::REQ_WORD) begin
          cmd_o.wdata = '0;
          priority if (word_addr == tsdg_pkg::SCRX0_ADDR ||
                       word_addr == tsdg_pkg::SCRX1_ADDR) begin
            cmd_o.op          = tsdg_pkg::OP_SCRX_WR;
            cmd_o.addr        = {10'd0, word_addr == tsdg_pkg::SCRX1_ADDR};
            cmd_o.wdata[9:0]  = bus_data_i[9:0];
          end else if (word_addr == tsdg_pkg::SCRY0_ADDR ||
                       word_addr == tsdg_pkg::SCRY1_ADDR) begin
            cmd_o.op          = tsdg_pkg::OP_SCRY_WR;
            cmd_o.addr        = {10'd0, word_addr == tsdg_pkg::SCRY1_ADDR};
            cmd_o.wdata[8:0]  = bus_data_i[8:0] + tsdg_pkg::SCRY_BIAS;
          end else begin
            mapped = 1'b0;
          end
        end else begin
          cmd_o.wdata = '0;
          priority if (bus_address_i == tsdg_pkg::BSEL_ADDR) begin
            cmd_o.op         = tsdg_pkg::OP_BSEL_WR;
            cmd_o.wdata[1:0] = byte_data[1:0];
          end else if (bus_address_i == tsdg_pkg::GBANK_ADDR) begin
            cmd_o.op         = tsdg_pkg::OP_GBANK_WR;
            cmd_o.wdata[3:0] = byte_data[3:0];
          end else begin
            mapped = 1'b0;
          end
        end
      end
      tsdg_pkg::REQ_TILE: begin
        // permuted map offset
        cmd_o.op   = tsdg_pkg::OP_TILE;
        cmd_o.addr = {item_index_i[5], item_index_i[10:6], item_index_i[4:0]};
      end
      tsdg_pkg::REQ_SPRITE: begin
        cmd_o.op = tsdg_pkg::OP_SPRITE;
      end
      default: begin
        mapped = 1'b0;
      end
    endcase
  end

  // unmapped writes are taken and dropped
  assign cmd_push_o = accept_i && mapped;

endmodule

// ----- src/tsdg_cmd_queue.sv -----
// two-entry command queue between the front and back parts
// depends on tsdg_pkg
module tsdg_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tsdg_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tsdg_pkg::cmd_t head_o
);

  tsdg_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_push;
  logic           do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- src/tsdg_back.sv -----
// back part: memories, scroll and bank registers, command sequencer, result queue
// depends on tsdg_pkg and tsdg_ram
module tsdg_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  tsdg_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  output logic              clearing_o,
  output logic              res_valid_o,
  output tsdg_pkg::result_t res_o,
  input  logic              res_pop_i
);

  localparam int unsigned MAW = tsdg_pkg::MAP_AW;
  localparam int unsigned SAW = tsdg_pkg::SPR_AW;
  localparam int unsigned SIW = tsdg_pkg::SPR_IDX_W;

  tsdg_pkg::back_state_e state_q, state_d;
  tsdg_pkg::cmd_t        cur_q, cur_d;
  logic [MAW-1:0]        clr_q, clr_d;
  logic [MAW-1:0]        map_addr_q, map_addr_d;
  logic [SIW-1:0]        spr_addr_q, spr_addr_d;
  logic                  spr_ok_q;
  logic [15:0]           v0_q, v0_d, v1_q, v1_d, v2_q, v2_d;
  logic [2:0]            y_q, y_d;
  logic [9:0]            scroll_x_q [2];
  logic [8:0]            scroll_y_q [2];
  logic [3:0]            gfx_bank_q [4];
  logic [1:0]            bank_sel_q;
  logic                  reg_we;

  // ram ports
  logic                  fg_we_hi, fg_we_lo, bg_we_hi, bg_we_lo, spr_we_hi, spr_we_lo;
  logic [MAW-1:0]        map_waddr;
  logic [SAW-1:0]        spr_waddr;
  logic [15:0]           ram_wdata;
  logic [15:0]           fg_rdata, bg_rdata, spr_rdata, spr_word;

  // result queue
  tsdg_pkg::result_t     res_q [2];
  logic                  res_wr_q, res_rd_q;
  logic [1:0]            res_cnt_q;
  logic                  res_full;
  logic                  res_push;
  tsdg_pkg::result_t     res_new;

  // result arithmetic
  logic [15:0]           attr;
  logic [10:0]           sxr;
  logic [8:0]            syr;
  logic signed [11:0]    tile_sx;
  logic signed [10:0]    tile_sy;
  logic [3:0]            spr_h;
  logic [2:0]            spr_hm1;
  logic [3:0]            spr_hy;
  logic [8:0]            spr_yt;
  logic [8:0]            spr_xt;
  logic                  spr_last;

  assign res_full = res_cnt_q == 2'd2;

  // sequencer
  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    clr_d      = clr_q;
    map_addr_d = map_addr_q;
    spr_addr_d = spr_addr_q;
    v0_d       = v0_q;
    v1_d       = v1_q;
    v2_d       = v2_q;
    y_d        = y_q;
    cmd_pop_o  = 1'b0;
    res_push   = 1'b0;
    reg_we     = 1'b0;
    fg_we_hi   = 1'b0;
    fg_we_lo   = 1'b0;
    bg_we_hi   = 1'b0;
    bg_we_lo   = 1'b0;
    spr_we_hi  = 1'b0;
    spr_we_lo  = 1'b0;
    map_waddr  = cmd_i.addr[MAW-1:0];
    spr_waddr  = cmd_i.addr[SAW-1:0];
    ram_wdata  = cmd_i.wdata;
    unique case (state_q)
      tsdg_pkg::B_CLEAR: begin
        // zero every map and sprite entry, one address a cycle
        fg_we_hi  = 1'b1;
        fg_we_lo  = 1'b1;
        bg_we_hi  = 1'b1;
        bg_we_lo  = 1'b1;
        spr_we_hi = 1'b1;
        spr_we_lo = 1'b1;
        map_waddr = clr_q;
        spr_waddr = clr_q[SAW-1:0];
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == MAW'(tsdg_pkg::MAP_TILES - 1)) begin
          state_d = tsdg_pkg::B_IDLE;
        end
      end
      tsdg_pkg::B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o  = 1'b1;
          cur_d      = cmd_i;
          map_addr_d = cmd_i.addr[MAW-1:0];
          spr_addr_d = {cmd_i.idx[7:0], 2'b00};
          unique case (cmd_i.op)
            tsdg_pkg::OP_FG_WR: begin
              fg_we_hi = cmd_i.lane_hi;
              fg_we_lo = cmd_i.lane_lo;
            end
            tsdg_pkg::OP_BG_WR: begin
              bg_we_hi = cmd_i.lane_hi;
              bg_we_lo = cmd_i.lane_lo;
            end
            tsdg_pkg::OP_SPR_WR: begin
              spr_we_hi = cmd_i.lane_hi;
              spr_we_lo = cmd_i.lane_lo;
            end
            tsdg_pkg::OP_SCRX_WR, tsdg_pkg::OP_SCRY_WR,
            tsdg_pkg::OP_BSEL_WR, tsdg_pkg::OP_GBANK_WR: begin
              reg_we = 1'b1;
            end
            tsdg_pkg::OP_TILE: begin
              state_d = tsdg_pkg::B_TILE;
            end
            tsdg_pkg::OP_SPRITE: begin
              state_d = tsdg_pkg::B_SPR0;
            end
            default: begin
            end
          endcase
        end
      end
      tsdg_pkg::B_TILE: begin
        // map address is held, so the read data stays valid while stalled
        if (!res_full) begin
          res_push = 1'b1;
          state_d  = tsdg_pkg::B_IDLE;
        end
      end
      tsdg_pkg::B_SPR0: begin
        v0_d       = spr_word;
        spr_addr_d = spr_addr_q + 1'b1;
        state_d    = tsdg_pkg::B_SPR1;
      end
      tsdg_pkg::B_SPR1: begin
        v1_d       = spr_word;
        spr_addr_d = spr_addr_q + 1'b1;
        state_d    = tsdg_pkg::B_SPR2;
      end
      tsdg_pkg::B_SPR2: begin
        v2_d    = spr_word;
        y_d     = 3'd0;
        state_d = tsdg_pkg::B_EMIT;
      end
      tsdg_pkg::B_EMIT: begin
        if (!res_full) begin
          res_push = 1'b1;
          y_d      = y_q + 1'b1;
          if (spr_last) begin
            state_d = tsdg_pkg::B_IDLE;
          end
        end
      end
      default: begin
        state_d = tsdg_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsdg_pkg::B_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // working registers of the current command
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    map_addr_q <= map_addr_d;
    spr_addr_q <= spr_addr_d;
    spr_ok_q   <= {1'b0, spr_addr_d} < (SIW + 1)'(tsdg_pkg::SPR_WORDS);
    v0_q       <= v0_d;
    v1_q       <= v1_d;
    v2_q       <= v2_d;
    y_q        <= y_d;
  end

  // scroll and bank registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_x_q[0] <= '0;
      scroll_x_q[1] <= '0;
      scroll_y_q[0] <= '0;
      scroll_y_q[1] <= '0;
      gfx_bank_q[0] <= '0;
      gfx_bank_q[1] <= '0;
      gfx_bank_q[2] <= '0;
      gfx_bank_q[3] <= '0;
      bank_sel_q    <= '0;
    end else if (reg_we) begin
      unique case (cmd_i.op)
        tsdg_pkg::OP_SCRX_WR:  scroll_x_q[cmd_i.addr[0]] <= cmd_i.wdata[9:0];
        tsdg_pkg::OP_SCRY_WR:  scroll_y_q[cmd_i.addr[0]] <= cmd_i.wdata[8:0];
        tsdg_pkg::OP_BSEL_WR:  bank_sel_q <= cmd_i.wdata[1:0];
        tsdg_pkg::OP_GBANK_WR: gfx_bank_q[bank_sel_q] <= cmd_i.wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  // memories, split into byte lanes
  tsdg_ram #(.Width(8), .Depth(tsdg_pkg::MAP_TILES)) u_fg_hi (
    .clk_i, .we_i(fg_we_hi), .waddr_i(map_waddr), .wdata_i(ram_wdata[15:8]),
    .raddr_i(map_addr_d), .rdata_o(fg_rdata[15:8])
  );
  tsdg_ram #(.Width(8), .Depth(tsdg_pkg::MAP_TILES)) u_fg_lo (
    .clk_i, .we_i(fg_we_lo), .waddr_i(map_waddr), .wdata_i(ram_wdata[7:0]),
    .raddr_i(map_addr_d), .rdata_o(fg_rdata[7:0])
  );
  tsdg_ram #(.Width(8), .Depth(tsdg_pkg::MAP_TILES)) u_bg_hi (
    .clk_i, .we_i(bg_we_hi), .waddr_i(map_waddr), .wdata_i(ram_wdata[15:8]),
    .raddr_i(map_addr_d), .rdata_o(bg_rdata[15:8])
  );
  tsdg_ram #(.Width(8), .Depth(tsdg_pkg::MAP_TILES)) u_bg_lo (
    .clk_i, .we_i(bg_we_lo), .waddr_i(map_waddr), .wdata_i(ram_wdata[7:0]),
    .raddr_i(map_addr_d), .rdata_o(bg_rdata[7:0])
  );
  tsdg_ram #(.Width(8), .Depth(tsdg_pkg::SPR_WORDS)) u_spr_hi (
    .clk_i, .we_i(spr_we_hi), .waddr_i(spr_waddr), .wdata_i(ram_wdata[15:8]),
    .raddr_i(spr_addr_d[SAW-1:0]), .rdata_o(spr_rdata[15:8])
  );
  tsdg_ram #(.Width(8), .Depth(tsdg_pkg::SPR_WORDS)) u_spr_lo (
    .clk_i, .we_i(spr_we_lo), .waddr_i(spr_waddr), .wdata_i(ram_wdata[7:0]),
    .raddr_i(spr_addr_d[SAW-1:0]), .rdata_o(spr_rdata[7:0])
  );

  // sprite words past the end read as zero
  assign spr_word = spr_ok_q ? spr_rdata : 16'd0;

  // layer tile position and code
  always_comb begin
    attr    = cur_q.layer ? bg_rdata : fg_rdata;
    sxr     = cur_q.layer ? {1'b0, scroll_x_q[1]} + tsdg_pkg::BG_SCRX_OFS
                          : {1'b0, scroll_x_q[0]} + tsdg_pkg::FG_SCRX_OFS;
    syr     = cur_q.layer ? scroll_y_q[1] : scroll_y_q[0];
    tile_sx = $signed({2'b00, cur_q.idx[5:0], 4'b0000}) - $signed({1'b0, sxr});
    if (tile_sx < 12'(tsdg_pkg::WRAP_LIMIT)) begin
      tile_sx = tile_sx + $signed(tsdg_pkg::X_WRAP);
    end
    tile_sy = $signed({2'b00, cur_q.idx[10:6], 4'b0000}) - $signed({2'b00, syr});
    if (tile_sy < 11'(tsdg_pkg::WRAP_LIMIT)) begin
      tile_sy = tile_sy + $signed(tsdg_pkg::Y_WRAP);
    end
  end

  // sprite column geometry
  always_comb begin
    spr_h    = 4'd1 << v0_q[10:9];
    spr_hm1  = 3'(spr_h - 4'd1);
    spr_hy   = spr_h - {1'b0, y_q};
    spr_yt   = v0_q[8:0] + tsdg_pkg::SPR_Y_BIAS + {1'b0, spr_hy, 4'b0000};
    spr_xt   = v2_q[8:0] + tsdg_pkg::SPR_X_BIAS;
    spr_last = y_q == spr_hm1;
  end

  // result word for the current state
  always_comb begin
    res_new = '0;
    if (state_q == tsdg_pkg::B_TILE) begin
      res_new.tile_code = {1'b0, gfx_bank_q[attr[11:10]], attr[9:0]};
      res_new.pos_x     = tile_sx[10:0];
      res_new.pos_y     = tile_sy[9:0];
      res_new.color     = {1'b0, cur_q.layer, !cur_q.layer, attr[15:12]};
      res_new.opaque    = cur_q.layer;
      res_new.last      = 1'b1;
    end else begin
      res_new.tile_code = v0_q[14] ? {1'b0, v1_q[13:0]} + 15'(spr_hm1) - 15'(y_q)
                                   : {1'b0, v1_q[13:0]} + 15'(y_q);
      res_new.pos_x     = $signed(tsdg_pkg::SPR_X_ORG - {2'b00, spr_xt});
      res_new.pos_y     = $signed(tsdg_pkg::SPR_Y_ORG - {1'b0, spr_yt});
      res_new.color     = v2_q[15:9];
      res_new.flip_x    = v0_q[13];
      res_new.flip_y    = v0_q[14];
      res_new.sprite_graphics = 1'b1;
      res_new.last      = spr_last;
    end
  end

  // two-entry result queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      if (res_push) begin
        res_wr_q <= !res_wr_q;
      end
      if (res_pop_i && res_valid_o) begin
        res_rd_q <= !res_rd_q;
      end
      res_cnt_q <= res_cnt_q + {1'b0, res_push} - {1'b0, res_pop_i && res_valid_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[res_wr_q] <= res_new;
    end
  end

  assign res_valid_o = res_cnt_q != 2'd0;
  assign res_o       = res_q[res_rd_q];
  assign clearing_o  = state_q == tsdg_pkg::B_CLEAR;

endmodule

// ----- src/tile_sprite_draw_command_generator_unit.sv -----
// top level of the tile and sprite draw command generator
// a layer tile request passes the command queue, map ram read and result queue;
// the sequencer takes commands in idle, does writes there, for a tile passes the tile
//   state, for a sprite reads three sprite ram words on one port, then gives h = 1, 2,
//   4 or 8 commands, one a cycle unless the result queue is full; reset: asynchronous,
//   active low, then a pass over every map address zeroes maps and sprite ram, full held high
module tile_sprite_draw_command_generator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         req_type_i,
  input  logic [23:0]        bus_address_i,
  input  logic [15:0]        bus_data_i,
  input  logic               layer_select_i,
  input  logic [10:0]        item_index_i,
  output logic               empty,
  input  logic               pop,
  output logic [14:0]        tile_code_o,
  output logic signed [10:0] pos_x_o,
  output logic signed [9:0]  pos_y_o,
  output logic [6:0]         color_o,
  output logic               flip_x_o,
  output logic               flip_y_o,
  output logic               sprite_graphics_o,
  output logic               opaque_o,
  output logic               last_o
);

  logic              accept;
  logic              cq_push;
  logic              cq_full;
  logic              cq_pop;
  logic              cq_valid;
  logic              clearing;
  logic              res_valid;
  tsdg_pkg::cmd_t    cq_in;
  tsdg_pkg::cmd_t    cq_head;
  tsdg_pkg::result_t res;

  assign full   = cq_full || clearing;
  assign accept = push && !full;

  // request decode
  tsdg_front u_front (
    .accept_i      (accept),
    .req_type_i    (req_type_i),
    .bus_address_i (bus_address_i),
    .bus_data_i    (bus_data_i),
    .layer_select_i(layer_select_i),
    .item_index_i  (item_index_i),
    .cmd_push_o    (cq_push),
    .cmd_o         (cq_in)
  );

  // decoupling queue
  tsdg_cmd_queue u_cmd_queue (
    .clk_i,
    .rst_ni,
    .push_i (cq_push),
    .cmd_i  (cq_in),
    .full_o (cq_full),
    .pop_i  (cq_pop),
    .valid_o(cq_valid),
    .head_o (cq_head)
  );

  // execution
  tsdg_back u_back (
    .clk_i,
    .rst_ni,
    .cmd_valid_i(cq_valid),
    .cmd_i      (cq_head),
    .cmd_pop_o  (cq_pop),
    .clearing_o (clearing),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_pop_i  (pop)
  );

  // result word on the ports
  assign empty             = !res_valid;
  assign tile_code_o       = res.tile_code;
  assign pos_x_o           = res.pos_x;
  assign pos_y_o           = res.pos_y;
  assign color_o           = res.color;
  assign flip_x_o          = res.flip_x;
  assign flip_y_o          = res.flip_y;
  assign sprite_graphics_o = res.sprite_graphics;
  assign opaque_o          = res.opaque;
  assign last_o            = res.last;

  // checks
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cq_push && cq_full))
    else $error("command queue written while full");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> (empty && !cq_valid))
    else $error("work in flight during clearing pass");

  a_tile_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !sprite_graphics_o) |-> (last_o && !flip_x_o && !flip_y_o))
    else $error("layer tile word is not a single unflipped command");

  a_no_pop_while_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !cq_pop)
    else $error("command taken during clearing pass");

endmodule
